[hdl/azt_pkg.sv]
// Shared types and constants for the six-axis auto-zero tare block.
// No dependencies; every other file imports this package.
package azt_pkg;

  localparam int SAMPLE_WIDTH = 32;
  localparam int EXTRA_READS  = 10;
  localparam int CHANNELS     = 6;
  localparam int RUN_W        = 8;
  localparam int READS_W      = 9;
  localparam int TOL_W        = 16;
  localparam int CFG_INDEX_W  = 1;
  localparam int CFG_DATA_W   = 16;

  localparam logic [RUN_W-1:0] REQUIRED_RESET  = 8'd10;
  localparam logic [TOL_W-1:0] TOLERANCE_RESET = 16'd0;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

  // Register indexes of the configuration port
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_REQUIRED  = 1'b0,
    REG_TOLERANCE = 1'b1
  } cfg_reg_t;

  // Calibration mode, also the reported status code
  typedef enum logic [1:0] {
    MODE_CAL   = 2'd0,
    MODE_VALID = 2'd1,
    MODE_FAIL  = 2'd2
  } cal_mode_t;

  // Per-channel test results
  typedef struct packed {
    logic nonzero;
    logic steady;
  } chan_flags_t;

  // Decisions from the calibration controller for the current beat
  typedef struct packed {
    logic      track;   // capture the reading as the previous sample
    logic      latch;   // capture the reading as the bias
    cal_mode_t mode;    // mode before this beat
    cal_mode_t status;  // mode after this beat
  } cal_ctrl_t;

endpackage

[hdl/azt_in_if.sv]
// Reading channel: valid/ready with one restart flag and six raw channels.
// Depends on azt_pkg.
interface azt_in_if import azt_pkg::*; ();
  logic    valid;
  logic    ready;
  logic    action;
  sample_t force_x;
  sample_t force_y;
  sample_t force_z;
  sample_t torque_x;
  sample_t torque_y;
  sample_t torque_z;

  modport source (output valid, action, force_x, force_y, force_z,
                  torque_x, torque_y, torque_z, input ready);
  modport sink   (input valid, action, force_x, force_y, force_z,
                  torque_x, torque_y, torque_z, output ready);
endinterface

[hdl/azt_out_if.sv]
// Result channel: valid/ready with six corrected channels and a status.
// Depends on azt_pkg.
interface azt_out_if import azt_pkg::*; ();
  logic       valid;
  logic       ready;
  sample_t    out_force_x;
  sample_t    out_force_y;
  sample_t    out_force_z;
  sample_t    out_torque_x;
  sample_t    out_torque_y;
  sample_t    out_torque_z;
  logic [1:0] cal_status;

  modport source (output valid, out_force_x, out_force_y, out_force_z,
                  out_torque_x, out_torque_y, out_torque_z, cal_status,
                  input ready);
  modport sink   (input valid, out_force_x, out_force_y, out_force_z,
                  out_torque_x, out_torque_y, out_torque_z, cal_status,
                  output ready);
endinterface

[hdl/azt_cfg_if.sv]
// Configuration write channel: valid/ready with register index and data.
// Depends on azt_pkg.
interface azt_cfg_if import azt_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[hdl/azt_chan.sv]
// One sensor channel: tolerance tests against zero and the previous reading,
// and the saturated bias subtraction. Purely combinational. Depends on azt_pkg.
module azt_chan import azt_pkg::*; (
  input  sample_t          sample,
  input  sample_t          prev,
  input  sample_t          bias,
  input  logic [TOL_W-1:0] tol,
  output chan_flags_t      flags,
  output sample_t          corrected
);

  localparam int EXT_W = SAMPLE_WIDTH + 1;

  logic signed [EXT_W-1:0] s_ext;
  logic signed [EXT_W-1:0] delta;
  logic signed [EXT_W-1:0] diff;
  logic        [EXT_W-1:0] s_mag;
  logic        [EXT_W-1:0] delta_mag;
  logic        [EXT_W-1:0] tol_ext;

  assign s_ext   = {sample[SAMPLE_WIDTH-1], sample};
  assign tol_ext = {{(EXT_W-TOL_W){1'b0}}, tol};

  // Magnitude tests against the tolerance
  assign delta     = s_ext - {prev[SAMPLE_WIDTH-1], prev};
  assign s_mag     = s_ext[EXT_W-1] ? -s_ext : s_ext;
  assign delta_mag = delta[EXT_W-1] ? -delta : delta;
  assign flags.nonzero = s_mag > tol_ext;
  assign flags.steady  = !(delta_mag > tol_ext);

  // Subtract the bias and clamp to the sample range
  assign diff = s_ext - {bias[SAMPLE_WIDTH-1], bias};
  always_comb begin
    if (diff[EXT_W-1] != diff[EXT_W-2]) begin
      corrected = diff[EXT_W-1] ? {1'b1, {(SAMPLE_WIDTH-1){1'b0}}}
                                : {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    end else begin
      corrected = diff[SAMPLE_WIDTH-1:0];
    end
  end

endmodule

[hdl/azt_ctrl.sv]
// Calibration controller: stable-run and read counters and the mode register.
// Depends on azt_pkg.
module azt_ctrl import azt_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,      // reading beat leaves the input register
  input  logic             restart,   // restart beat leaves the input register
  input  logic             stable,
  input  logic [RUN_W-1:0] required,
  output cal_ctrl_t        ctrl
);

  cal_mode_t          mode, mode_next;
  logic [RUN_W-1:0]   stable_run, stable_run_next;
  logic [READS_W-1:0] reads_taken, reads_taken_next;
  logic [READS_W-1:0] read_limit;

  assign read_limit = {1'b0, required} + READS_W'(EXTRA_READS);

  // Hold mode and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_CAL;
      stable_run  <= '0;
      reads_taken <= '0;
    end else begin
      mode        <= mode_next;
      stable_run  <= stable_run_next;
      reads_taken <= reads_taken_next;
    end
  end

  // Advance the calibration on each beat
  always_comb begin
    mode_next        = mode;
    stable_run_next  = stable_run;
    reads_taken_next = reads_taken;
    ctrl.track       = 1'b0;
    ctrl.latch       = 1'b0;
    if (restart) begin
      mode_next        = MODE_CAL;
      stable_run_next  = '0;
      reads_taken_next = '0;
    end else if (step) begin
      case (mode)
        MODE_CAL: begin
          if (required == '0) begin
            mode_next = MODE_VALID;
          end else begin
            ctrl.track       = 1'b1;
            stable_run_next  = stable ? stable_run + 1'b1 : '0;
            reads_taken_next = reads_taken + 1'b1;
            if (stable_run_next >= required) begin
              ctrl.latch = 1'b1;
              mode_next  = MODE_VALID;
            end else if (reads_taken_next >= read_limit) begin
              mode_next = MODE_FAIL;
            end
          end
        end
        MODE_VALID: mode_next = MODE_VALID;
        MODE_FAIL:  mode_next = MODE_FAIL;
        default:    mode_next = MODE_CAL;
      endcase
    end
    ctrl.mode   = mode;
    ctrl.status = mode_next;
  end

endmodule

[hdl/six_axis_auto_zero_tare.sv]
// Six-axis auto-zero tare: top level with input and result registers.
// Depends on azt_pkg, azt_in_if, azt_out_if, azt_cfg_if, azt_chan, azt_ctrl.
//
// Usage:
//   samples carries one beat per item: action 0 is a six-channel Q16.16
//   reading, action 1 restarts calibration. results returns one beat per
//   item with each channel minus its bias (saturated) and cal_status
//   (0 calibrating, 1 bias valid, 2 failed). cfg writes required_stable
//   (index 0) and tolerance (index 1); it is always ready and is meant to
//   be written only while no item is in flight.
//   An accepted beat passes from the input register to the result register.
//   Throughput: one item per cycle while results is not stalled, set by the
//   channel compare/subtract stage that also updates the bias, previous
//   sample and counters.
//   Reset clears the bias and previous sample, zeroes the counters, starts
//   calibration and sets required_stable to 10 and tolerance to 0.
//   When results stalls, the result register holds and the input register
//   takes one more beat; samples.ready then drops until results drains.
module six_axis_auto_zero_tare import azt_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  azt_in_if.sink   samples,
  azt_out_if.source results,
  azt_cfg_if.sink  cfg
);

  // Configuration registers
  logic [RUN_W-1:0] required_stable;
  logic [TOL_W-1:0] tolerance;

  // Input register
  logic    in_full;
  logic    in_action;
  sample_t in_s [CHANNELS];

  // Calibration state
  sample_t bias_store [CHANNELS];
  sample_t previous_sample [CHANNELS];

  // Result register
  logic       out_full;
  sample_t    out_s [CHANNELS];
  logic [1:0] out_status;

  logic        advance;
  logic        any_nonzero;
  logic        all_steady;
  chan_flags_t flags [CHANNELS];
  sample_t     corrected [CHANNELS];
  cal_ctrl_t   ctrl;

  assign cfg.ready     = 1'b1;
  assign advance       = in_full && (!out_full || results.ready);
  assign samples.ready = !in_full || advance;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      required_stable <= REQUIRED_RESET;
      tolerance       <= TOLERANCE_RESET;
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.index))
        REG_REQUIRED:  required_stable <= cfg.data[RUN_W-1:0];
        REG_TOLERANCE: tolerance       <= cfg.data[TOL_W-1:0];
        default:       required_stable <= required_stable;
      endcase
    end
  end

  // Capture an accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (samples.ready) begin
      in_full <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) begin
      in_action <= samples.action;
      in_s[0]   <= samples.force_x;
      in_s[1]   <= samples.force_y;
      in_s[2]   <= samples.force_z;
      in_s[3]   <= samples.torque_x;
      in_s[4]   <= samples.torque_y;
      in_s[5]   <= samples.torque_z;
    end
  end

  // Per-channel tests and correction
  for (genvar j = 0; j < CHANNELS; j++) begin : g_chan
    azt_chan u_chan (
      .sample    (in_s[j]),
      .prev      (previous_sample[j]),
      .bias      (bias_store[j]),
      .tol       (tolerance),
      .flags     (flags[j]),
      .corrected (corrected[j])
    );
  end

  always_comb begin
    any_nonzero = 1'b0;
    all_steady  = 1'b1;
    for (int j = 0; j < CHANNELS; j++) begin
      any_nonzero = any_nonzero | flags[j].nonzero;
      all_steady  = all_steady & flags[j].steady;
    end
  end

  azt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .step     (advance && !in_action),
    .restart  (advance && in_action),
    .stable   (any_nonzero && all_steady),
    .required (required_stable),
    .ctrl     (ctrl)
  );

  // Update bias and previous sample
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < CHANNELS; j++) begin
        bias_store[j]      <= '0;
        previous_sample[j] <= '0;
      end
    end else if (advance) begin
      for (int j = 0; j < CHANNELS; j++) begin
        if (in_action) begin
          bias_store[j]      <= '0;
          previous_sample[j] <= '0;
        end else begin
          if (ctrl.track) previous_sample[j] <= in_s[j];
          if (ctrl.latch) bias_store[j]      <= in_s[j];
        end
      end
    end
  end

  // Result register; a latching or restart beat reports zero channels
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (advance) begin
      out_full <= 1'b1;
    end else if (results.ready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int j = 0; j < CHANNELS; j++) begin
        out_s[j] <= (in_action || ctrl.latch) ? '0 : corrected[j];
      end
      out_status <= in_action ? MODE_CAL : ctrl.status;
    end
  end

  assign results.valid        = out_full;
  assign results.out_force_x  = out_s[0];
  assign results.out_force_y  = out_s[1];
  assign results.out_force_z  = out_s[2];
  assign results.out_torque_x = out_s[3];
  assign results.out_torque_y = out_s[4];
  assign results.out_torque_z = out_s[5];
  assign results.cal_status   = out_status;

`ifndef NO_ASSERTIONS
  // A latching reading reports zero on force_x and torque_z and a valid bias
  a_latch_zero: assert property (@(posedge clk) disable iff (rst)
    advance && ctrl.latch |=> results.valid && results.cal_status == MODE_VALID &&
      results.out_force_x == '0 && results.out_torque_z == '0)
    else $error("latching reading did not report a zero result");

  // The force_x and torque_z bias stays zero unless calibration has succeeded
  a_bias_zero: assert property (@(posedge clk) disable iff (rst)
    ctrl.mode != MODE_VALID |-> bias_store[0] == '0 && bias_store[5] == '0)
    else $error("bias nonzero outside valid mode");

  // A held input beat is not lost while the result side is stalled
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_full && !advance |=> in_full && $stable(in_action))
    else $error("input register dropped a waiting beat");
`endif

endmodule
